// ===== rtl/srbt_pkg.sv =====
// ----------------------------------------------------------------------------
// srbt_pkg: shared types and constants of the sequence range blacklist table
// Entry and control types, operation and status codes, field widths.
// ----------------------------------------------------------------------------
package srbt_pkg;

  localparam int MAX_RANGES = 16;
  localparam int STEP_W     = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int SEQ_W      = 64;
  localparam int IN_W       = 264;
  localparam int OUT_W      = 72;

  localparam logic [SEQ_W-1:0] U64_MAX = {SEQ_W{1'b1}};

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_QUERY    = 3'd1,
    OP_NEXT_BL  = 3'd2,
    OP_NEXT_OK  = 3'd3,
    OP_LAST_BL  = 3'd4,
    OP_COLLECT  = 3'd5
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD,
    S_COUNT,
    S_WALK,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [SEQ_W-1:0] start_seq;
    logic [SEQ_W-1:0] end_seq;
    logic             dirty;
  } entry_t;

  typedef struct packed {
    logic              shift;
    logic              wr;
    logic [STEP_W-1:0] wr_idx;
    entry_t            wr_data;
    logic              clr;
    logic [CNT_W-1:0]  clr_from;
  } cell_ctl_t;

endpackage

// ===== rtl/srbt_cell.sv =====
// ----------------------------------------------------------------------------
// srbt_cell: one table entry of the rotating chain
// Takes its neighbor's entry on a shift; a write aimed at it takes priority.
// ----------------------------------------------------------------------------
module srbt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [srbt_pkg::STEP_W-1:0] idx,
  input  srbt_pkg::cell_ctl_t       ctl,
  input  srbt_pkg::entry_t          nbr,
  output srbt_pkg::entry_t          q
);
  import srbt_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.shift) begin
      ent_nxt = nbr;
    end
    if (ctl.wr && (ctl.wr_idx == idx)) begin
      ent_nxt = ctl.wr_data;
    end
    if (ctl.clr && (CNT_W'(idx) >= ctl.clr_from)) begin
      ent_nxt.dirty = 1'b0;
    end
  end

  // Only the dirty mark is reset; the range fields are don't-care until written.
  always_ff @(posedge clk) begin
    ent_r.start_seq <= ent_nxt.start_seq;
    ent_r.end_seq   <= ent_nxt.end_seq;
    if (!rst_n) begin
      ent_r.dirty <= 1'b0;
    end else begin
      ent_r.dirty <= ent_nxt.dirty;
    end
  end

  assign q = ent_r;

endmodule

// ===== rtl/srbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// srbt_ctrl: sequencer of the blacklist table
// Walks the entries as they leave the head of the chain and writes the
// rebuilt table back into the chain; holds the result register.
// ----------------------------------------------------------------------------
module srbt_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [srbt_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [srbt_pkg::OUT_W-1:0] out_tdata,
  input  srbt_pkg::entry_t           head,
  output srbt_pkg::cell_ctl_t        ctl
);
  import srbt_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] t_r, t_nxt;
  logic [2:0]        op_r, op_nxt;
  logic [SEQ_W-1:0]  s_r, s_nxt, e_r, e_nxt, seq_r, seq_nxt, old_r, old_nxt;
  logic              md_r, md_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt, n_r, n_nxt, kc_r, kc_nxt;
  entry_t            pend_r, pend_nxt;
  logic              pend_v_r, pend_v_nxt, placed_r, placed_nxt;
  logic              found_r, found_nxt, hit_r, hit_nxt;
  logic [SEQ_W-1:0]  res_r, res_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  logic              valid_k, ov, in_rng, last_step;
  logic [CNT_W:0]    w_full;
  logic [STEP_W-1:0] w_idx;
  entry_t            merged, head_clean;
  logic [31:0]       cnt32;

  assign valid_k   = CNT_W'(t_r) < count_r;
  assign ov        = (head.end_seq >= s_r) && (head.start_seq <= e_r);
  assign in_rng    = (head.start_seq <= seq_r) && (seq_r < head.end_seq);
  assign last_step = t_r == STEP_W'(MAX_RANGES - 1);
  // Entry number n lands in place after the remaining shifts of the walk.
  assign w_full    = (CNT_W + 1)'(MAX_RANGES - 1) - (CNT_W + 1)'(t_r) + {1'b0, n_r};
  assign w_idx     = w_full[STEP_W-1:0];
  assign merged    = '{start_seq: s_r, end_seq: e_r, dirty: 1'b0};
  assign head_clean = '{start_seq: head.start_seq, end_seq: head.end_seq, dirty: 1'b0};

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    t_nxt         = t_r;
    op_nxt        = op_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    seq_nxt       = seq_r;
    old_nxt       = old_r;
    md_nxt        = md_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    kc_nxt        = kc_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    placed_nxt    = placed_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cnt32         = '0;
    ctl           = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt     = in_tdata[2:0];
          s_nxt      = in_tdata[66:3];
          e_nxt      = in_tdata[130:67];
          seq_nxt    = in_tdata[194:131];
          md_nxt     = in_tdata[195];
          old_nxt    = in_tdata[259:196];
          t_nxt      = '0;
          n_nxt      = '0;
          kc_nxt     = '0;
          pend_v_nxt = 1'b0;
          placed_nxt = 1'b0;
          found_nxt  = 1'b0;
          hit_nxt    = 1'b0;
          status_nxt = ST_OK;
          case (in_tdata[2:0])
            OP_NEXT_BL, OP_LAST_BL: res_nxt = U64_MAX;
            OP_NEXT_OK:             res_nxt = in_tdata[194:131];
            default:                res_nxt = '0;
          endcase
          if (in_tdata[2:0] == OP_ADD) begin
            if (in_tdata[66:3] >= in_tdata[130:67]) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_FIN;
            end else begin
              state_nxt = S_FOLD;
            end
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_FOLD: begin
        ctl.shift = 1'b1;
        if (valid_k && ov) begin
          if (head.start_seq < s_r) s_nxt = head.start_seq;
          if (head.end_seq > e_r)   e_nxt = head.end_seq;
        end
        t_nxt = t_r + 1'b1;
        if (last_step) begin
          t_nxt     = '0;
          state_nxt = S_COUNT;
        end
      end

      S_COUNT: begin
        ctl.shift = 1'b1;
        if (valid_k && !ov) begin
          kc_nxt = kc_r + 1'b1;
        end
        t_nxt = t_r + 1'b1;
        if (last_step) begin
          t_nxt = '0;
          // The merged range needs one slot besides every entry kept.
          if (kc_nxt == CNT_W'(MAX_RANGES)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_WALK;
          end
        end
      end

      S_WALK: begin
        ctl.shift  = 1'b1;
        ctl.wr_idx = w_idx;
        case (op_r)
          OP_ADD: begin
            // A held entry delays the stream by one slot until a merged or
            // empty slot comes by.
            if (pend_v_r) begin
              ctl.wr      = 1'b1;
              ctl.wr_data = pend_r;
              if (valid_k && !ov) begin
                pend_nxt = head_clean;
              end else begin
                pend_v_nxt = 1'b0;
              end
            end else if (valid_k && !ov) begin
              ctl.wr = 1'b1;
              if (!placed_r && (head.start_seq > e_r)) begin
                ctl.wr_data = merged;
                pend_nxt    = head_clean;
                pend_v_nxt  = 1'b1;
                placed_nxt  = 1'b1;
              end else begin
                ctl.wr_data = head_clean;
              end
            end else if (!valid_k && !placed_r) begin
              ctl.wr      = 1'b1;
              ctl.wr_data = merged;
              placed_nxt  = 1'b1;
            end
          end
          OP_QUERY: begin
            if (valid_k && !found_r && in_rng) begin
              found_nxt = 1'b1;
              hit_nxt   = 1'b1;
              if (md_r) begin
                ctl.wr          = 1'b1;
                ctl.wr_idx      = STEP_W'(MAX_RANGES - 1);
                ctl.wr_data     = head;
                ctl.wr_data.dirty = 1'b1;
              end
            end
          end
          OP_NEXT_BL: begin
            if (valid_k && !found_r && (head.end_seq > seq_r)) begin
              found_nxt = 1'b1;
              res_nxt   = (head.start_seq > seq_r) ? head.start_seq : seq_r;
            end
          end
          OP_NEXT_OK: begin
            if (valid_k && (head.start_seq <= res_r) && (res_r < head.end_seq)) begin
              res_nxt = head.end_seq;
            end
          end
          OP_LAST_BL: begin
            if ((CNT_W'(t_r) + 1'b1) == count_r) begin
              res_nxt = head.end_seq - 1'b1;
            end
          end
          OP_COLLECT: begin
            if (valid_k && (head.dirty || (head.end_seq >= old_r))) begin
              ctl.wr      = 1'b1;
              ctl.wr_data = head;
            end
          end
          default: begin
          end
        endcase
        if (ctl.wr && (op_r != OP_QUERY)) begin
          n_nxt = n_r + 1'b1;
        end
        t_nxt = t_r + 1'b1;
        if (last_step) begin
          t_nxt     = '0;
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          if ((op_r == OP_ADD) && (status_r == ST_OK)) begin
            ctl.wr_idx   = n_r[STEP_W-1:0];
            ctl.clr      = 1'b1;
            ctl.clr_from = '0;
            count_nxt    = n_r;
            if (pend_v_r) begin
              ctl.wr      = 1'b1;
              ctl.wr_data = pend_r;
              count_nxt   = n_r + 1'b1;
            end else if (!placed_r) begin
              ctl.wr      = 1'b1;
              ctl.wr_data = merged;
              count_nxt   = n_r + 1'b1;
            end
          end else if (op_r == OP_COLLECT) begin
            ctl.clr      = 1'b1;
            ctl.clr_from = n_r;
            count_nxt    = n_r;
            hit_nxt      = n_r != count_r;
          end
          cnt32         = 32'(count_nxt);
          out_valid_nxt = 1'b1;
          out_data_nxt  = {cnt32[4:0], res_r, hit_nxt, status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      t_r         <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      t_r         <= t_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    seq_r      <= seq_nxt;
    old_r      <= old_nxt;
    md_r       <= md_nxt;
    n_r        <= n_nxt;
    kc_r       <= kc_nxt;
    pend_r     <= pend_nxt;
    pend_v_r   <= pend_v_nxt;
    placed_r   <= placed_nxt;
    found_r    <= found_nxt;
    hit_r      <= hit_nxt;
    res_r      <= res_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/sequence_range_blacklist_table.sv =====
// ----------------------------------------------------------------------------
// sequence_range_blacklist_table: sorted table of blacklisted sequence ranges
// Disjoint half-open ranges kept in a rotating chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
// One operation item enters on the in_ stream; exactly one result item leaves
// on the out_ stream. Input tdata carries op, range_start, range_end, seq,
// mark_dirty and oldest_seq; output tdata carries status, hit, result_seq and
// entry_count.
// The entries sit in a ring of MAX_RANGES cells that rotates by one entry per
// cycle while an operation is worked; the sequencer inspects the entry at the
// head and writes rebuilt entries back into the ring. Every operation but an
// add is one full turn of the ring plus one finishing step. An add takes three
// turns (fold, count, rebuild); an add that would overflow the table is
// answered after the count turn, and an empty range goes straight to the
// finishing step.
// One item is worked at a time; in_tready is high while the sequencer idles,
// also while an earlier result still waits in the output register.
// If the receiver stalls, the finished result waits until that register
// frees up. Reset empties the table and clears all dirty marks at once.
// ----------------------------------------------------------------------------
module sequence_range_blacklist_table (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[2:0], range_start[66:3], range_end[130:67], seq[194:131],
  // mark_dirty[195], oldest_seq[259:196], zero fill[263:260]
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], hit[2], result_seq[66:3], entry_count[71:67]
  output logic [71:0]  out_tdata
);
  import srbt_pkg::*;

  entry_t    q [MAX_RANGES];
  cell_ctl_t ctl;

  srbt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .head       (q[0]),
    .ctl        (ctl)
  );

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    localparam int NX = (i + 1) % MAX_RANGES;
    srbt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .idx   (STEP_W'(i)),
      .ctl   (ctl),
      .nbr   (q[NX]),
      .q     (q[i])
    );
  end

endmodule

// ===== rtl/srbt_checker.sv =====
// ----------------------------------------------------------------------------
// srbt_checker: port checks of the sequence range blacklist table
// Watches the input and result streams and is bound to the top level.
// ----------------------------------------------------------------------------
module srbt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [71:0]  out_tdata
);
  import srbt_pkg::*;

  // A held result must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A rejected add reports no hit and no sequence.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] != ST_OK) |-> !out_tdata[2] && (out_tdata[66:3] == '0))
    else $error("rejected add carries data");

  // Only one item is worked at a time, so the input closes after an accept.
  a_in_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sequence_range_blacklist_table srbt_checker u_srbt_checker (.*);

// ===== dv/sequence_range_blacklist_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_range_blacklist_table_tb: self-checking bench for the range table
// Drives directed and random operation items with random gaps on both
// streams, predicts every result from a local copy of the table and compares
// each result item field by field, in order.
// ----------------------------------------------------------------------------
module sequence_range_blacklist_table_tb;
  import srbt_pkg::*;

  localparam logic [2:0] OP_UNUSED6 = 3'd6;
  localparam logic [2:0] OP_UNUSED7 = 3'd7;
  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [2:0]       op;
    logic [SEQ_W-1:0] rs;
    logic [SEQ_W-1:0] re;
    logic [SEQ_W-1:0] seq;
    logic             md;
    logic [SEQ_W-1:0] oldest;
  } op_item_t;

  typedef struct {
    logic [1:0]       status;
    logic             hit;
    logic [SEQ_W-1:0] res;
    logic [4:0]       cnt;
  } answer_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [263:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata;

  logic [SEQ_W-1:0] tbl_start [MAX_RANGES];
  logic [SEQ_W-1:0] tbl_end   [MAX_RANGES];
  logic             tbl_dirty [MAX_RANGES];
  int               tbl_count;

  answer_t pending_answers[$];
  int  error_count;
  int  items_sent;
  int  answers_seen;
  int  idle_cycles;
  bit  no_idle;
  bit  hold_req;

  sequence_range_blacklist_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic answer_t predict_table_op(op_item_t it);
    answer_t a;
    logic [SEQ_W-1:0] s, e;
    logic [SEQ_W-1:0] ns [MAX_RANGES+1];
    logic [SEQ_W-1:0] ne [MAX_RANGES+1];
    int n;
    bit placed;
    a.status = ST_OK;
    a.hit = 1'b0;
    a.res = '0;
    case (it.op)
      OP_ADD: begin
        s = it.rs;
        e = it.re;
        n = 0;
        placed = 0;
        if (s >= e) begin
          a.status = ST_EMPTY;
        end else begin
          for (int k = 0; k < tbl_count; k++) begin
            if (e >= tbl_start[k] && s <= tbl_end[k]) begin
              if (tbl_start[k] < s) s = tbl_start[k];
              if (tbl_end[k] > e) e = tbl_end[k];
            end
          end
          for (int k = 0; k < tbl_count; k++) begin
            if (!(tbl_end[k] >= s && tbl_start[k] <= e)) begin
              if (!placed && tbl_start[k] > e) begin
                ns[n] = s; ne[n] = e; n++;
                placed = 1;
              end
              ns[n] = tbl_start[k]; ne[n] = tbl_end[k]; n++;
            end
          end
          if (!placed) begin
            ns[n] = s; ne[n] = e; n++;
          end
          if (n > MAX_RANGES) begin
            a.status = ST_FULL;
          end else begin
            for (int k = 0; k < n; k++) begin
              tbl_start[k] = ns[k];
              tbl_end[k] = ne[k];
            end
            for (int k = 0; k < MAX_RANGES; k++) tbl_dirty[k] = 1'b0;
            tbl_count = n;
          end
        end
      end
      OP_QUERY: begin
        for (int k = 0; k < tbl_count; k++) begin
          if (!a.hit && tbl_start[k] <= it.seq && it.seq < tbl_end[k]) begin
            a.hit = 1'b1;
            if (it.md) tbl_dirty[k] = 1'b1;
          end
        end
      end
      OP_NEXT_BL: begin
        a.res = U64_MAX;
        for (int k = 0; k < tbl_count; k++) begin
          if (!placed && tbl_end[k] > it.seq) begin
            a.res = (tbl_start[k] > it.seq) ? tbl_start[k] : it.seq;
            placed = 1;
          end
        end
      end
      OP_NEXT_OK: begin
        a.res = it.seq;
        for (int k = 0; k < tbl_count; k++) begin
          if (tbl_start[k] <= a.res && a.res < tbl_end[k]) a.res = tbl_end[k];
        end
      end
      OP_LAST_BL: begin
        a.res = (tbl_count != 0) ? tbl_end[tbl_count-1] - 1'b1 : U64_MAX;
      end
      OP_COLLECT: begin
        n = 0;
        for (int k = 0; k < tbl_count; k++) begin
          if (tbl_dirty[k] || tbl_end[k] >= it.oldest) begin
            tbl_start[n] = tbl_start[k];
            tbl_end[n] = tbl_end[k];
            tbl_dirty[n] = tbl_dirty[k];
            n++;
          end
        end
        for (int k = n; k < tbl_count; k++) tbl_dirty[k] = 1'b0;
        a.hit = (n != tbl_count);
        tbl_count = n;
      end
      default: begin
      end
    endcase
    a.cnt = tbl_count[4:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [SEQ_W-1:0] got,
                                 logic [SEQ_W-1:0] want);
    error_count++;
    $display("MISMATCH %s at answer %0d: got 0x%0h, want 0x%0h",
             what, answers_seen, got, want);
  endtask

  // Sender: random gap, then hold the item until the block takes it.
  task automatic send_item(op_item_t it);
    int gap;
    bit ready_seen;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, it.oldest, it.md, it.seq, it.re, it.rs, it.op};
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
    pending_answers.push_back(predict_table_op(it));
    items_sent++;
  endtask

  task automatic finish_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SEQ_W-1:0] pick_seq();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 64'($urandom_range(0, 300));
    if (r < 80) return U64_MAX - 64'($urandom_range(0, 300));
    return {$urandom(), $urandom()};
  endfunction

  function automatic op_item_t make_item(logic [2:0] op, logic [SEQ_W-1:0] rs,
                                         logic [SEQ_W-1:0] re,
                                         logic [SEQ_W-1:0] seq, logic md,
                                         logic [SEQ_W-1:0] oldest);
    op_item_t it;
    it.op = op; it.rs = rs; it.re = re; it.seq = seq; it.md = md;
    it.oldest = oldest;
    return it;
  endfunction

  function automatic op_item_t random_item();
    op_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) it.op = OP_ADD;
    else if (r < 60) it.op = OP_QUERY;
    else if (r < 68) it.op = OP_NEXT_BL;
    else if (r < 76) it.op = OP_NEXT_OK;
    else if (r < 84) it.op = OP_LAST_BL;
    else if (r < 95) it.op = OP_COLLECT;
    else it.op = 3'($urandom_range(6, 7));
    it.rs = pick_seq();
    // Short ranges near the start merge often; a few end anywhere.
    it.re = ($urandom_range(0, 9) < 8) ? it.rs + 64'($urandom_range(0, 20))
                                       : pick_seq();
    it.seq = pick_seq();
    it.md = 1'($urandom_range(0, 1));
    it.oldest = pick_seq();
    return it;
  endfunction

  task automatic test_directed();
    send_item(make_item(OP_LAST_BL, 0, 0, 0, 0, 0));
    send_item(make_item(OP_NEXT_BL, 0, 0, 5, 0, 0));
    send_item(make_item(OP_NEXT_OK, 0, 0, U64_MAX, 0, 0));
    send_item(make_item(OP_ADD, 7, 7, 0, 0, 0));
    send_item(make_item(OP_ADD, U64_MAX, 0, 0, 0, 0));
    send_item(make_item(OP_ADD, 0, 1, 0, 0, 0));
    send_item(make_item(OP_ADD, U64_MAX - 1, U64_MAX, 0, 0, 0));
    send_item(make_item(OP_ADD, 10, 20, 0, 0, 0));
    send_item(make_item(OP_ADD, 20, 30, 0, 0, 0));
    send_item(make_item(OP_ADD, 5, 12, 0, 0, 0));
    send_item(make_item(OP_QUERY, 0, 0, 29, 1, 0));
    send_item(make_item(OP_QUERY, 0, 0, 30, 1, 0));
    send_item(make_item(OP_QUERY, 0, 0, U64_MAX - 1, 0, 0));
    send_item(make_item(OP_NEXT_BL, 0, 0, 2, 0, 0));
    send_item(make_item(OP_NEXT_OK, 0, 0, 5, 0, 0));
    send_item(make_item(OP_NEXT_BL, 0, 0, U64_MAX, 0, 0));
    send_item(make_item(OP_LAST_BL, 0, 0, 0, 0, 0));
    // The dirty range must survive; the clean one below oldest goes.
    send_item(make_item(OP_COLLECT, 0, 0, 0, 0, 100));
    send_item(make_item(OP_COLLECT, 0, 0, 0, 0, U64_MAX));
    send_item(make_item(OP_UNUSED6, 1, 9, 3, 1, 4));
    send_item(make_item(OP_UNUSED7, U64_MAX, U64_MAX, U64_MAX, 1, U64_MAX));
    send_item(make_item(OP_COLLECT, 0, 0, 0, 0, U64_MAX));
  endtask

  task automatic test_table_full();
    for (int k = 0; k < MAX_RANGES + 1; k++) begin
      send_item(make_item(OP_ADD, 64'(1000 + 4 * k), 64'(1002 + 4 * k), 0, 0, 0));
    end
    // A bridging add still fits because it shrinks the table.
    send_item(make_item(OP_ADD, 1001, 1005, 0, 0, 0));
    send_item(make_item(OP_COLLECT, 0, 0, 0, 0, U64_MAX));
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) begin
      no_idle = (k / 100) % 4 == 3;
      send_item(random_item());
    end
    no_idle = 0;
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    no_idle = 1;
    for (int k = 0; k < 8; k++) send_item(random_item());
    no_idle = 0;
  endtask

  task automatic test_drain_pause();
    finish_sending();
    wait (pending_answers.size() == 0);
    repeat (60) @(posedge clk);
    for (int k = 0; k < 10; k++) send_item(random_item());
  endtask

  // Receiver: random stalls, one long hold when asked.
  initial begin
    int n;
    bit valid_seen;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        n = HOLD_CYCLES;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 10);
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        valid_seen = out_tvalid;
        @(posedge clk);
      end while (!valid_seen);
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        $display("MISMATCH unexpected answer item 0x%0h", out_tdata);
      end else begin
        want = pending_answers.pop_front();
        if (out_tdata[1:0] !== want.status)
          report_mismatch("status", 64'(out_tdata[1:0]), 64'(want.status));
        if (out_tdata[2] !== want.hit)
          report_mismatch("hit", 64'(out_tdata[2]), 64'(want.hit));
        if (out_tdata[66:3] !== want.res)
          report_mismatch("result_seq", out_tdata[66:3], want.res);
        if (out_tdata[71:67] !== want.cnt)
          report_mismatch("entry_count", 64'(out_tdata[71:67]), 64'(want.cnt));
      end
      answers_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
        $display("sequence_range_blacklist_table_tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    error_count = 0;
    items_sent = 0;
    answers_seen = 0;
    idle_cycles = 0;
    no_idle = 0;
    hold_req = 0;
    tbl_count = 0;
    for (int k = 0; k < MAX_RANGES; k++) begin
      tbl_start[k] = '0;
      tbl_end[k] = '0;
      tbl_dirty[k] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_table_full();
    test_random(400);
    test_backpressure();
    test_drain_pause();
    test_random(400);
    finish_sending();

    wait (pending_answers.size() == 0);
    repeat (100) @(posedge clk);
    $display("Covered %0d items over all ops, merges, full table and collects,",
             items_sent);
    $display("with random gaps, a long output hold and a drain pause.");
    if (error_count == 0 && pending_answers.size() == 0) begin
      $display("sequence_range_blacklist_table_tb passed");
    end else begin
      $display("sequence_range_blacklist_table_tb failed");
    end
    $finish;
  end

endmodule
